[src/tpfe_pkg.sv]
// ---------------------------------------------------------------------------
// tpfe_pkg
// Shared types and codes for the TLV packet field extractor.
// ---------------------------------------------------------------------------
package tpfe_pkg;

  localparam int MAX_COMPONENTS_DEF = 16;
  localparam int MAX_RESULTS        = 4;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NAME_TYPE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METADATA_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TYPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_TYPE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHUNK_TYPE = 3'd4;

  // register reset values
  localparam logic [15:0] RST_NAME_TYPE      = 16'd0;
  localparam logic [15:0] RST_METADATA_TYPE  = 16'd1;
  localparam logic [15:0] RST_PAYLOAD_TYPE   = 16'd2;
  localparam logic [15:0] RST_CHUNK_TYPE     = 16'd4;
  localparam logic [15:0] RST_END_CHUNK_TYPE = 16'd6;

  // result kinds
  localparam logic [2:0] KIND_COMPONENT = 3'd0;
  localparam logic [2:0] KIND_NAME_SPAN = 3'd1;
  localparam logic [2:0] KIND_CHUNK     = 3'd2;
  localparam logic [2:0] KIND_END_CHUNK = 3'd3;
  localparam logic [2:0] KIND_DONE      = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_SHORT_MSG_HDR = 3'd1;
  localparam logic [2:0] ST_TRAILING      = 3'd2;
  localparam logic [2:0] ST_TRUNC_COMP    = 3'd3;
  localparam logic [2:0] ST_TRUNC_META    = 3'd4;
  localparam logic [2:0] ST_OVERRUN       = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] header_length;
  } byte_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [4:0]  index;
    logic [31:0] number;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic        payload_seen;
    logic [2:0]  status;
    logic        last_result;
  } result_beat_t;

endpackage

[src/tlv_packet_field_extractor.sv]
// ---------------------------------------------------------------------------
// tlv_packet_field_extractor
// Streaming parser for TLV messages with 2-byte type and length headers.
// ---------------------------------------------------------------------------
// One message byte is taken per beat. The parser updates its state in the
// cycle after a byte is accepted and loads the results of that byte (zero to
// four) into a result bundle register, which drains one result per cycle into
// the output register while the output is not stalled. A byte that yields
// more than one result holds the input side while the bundle drains; the next
// byte is taken as the last result moves to the output. Sustained rate on
// ordinary traffic is one byte per cycle when the output does not stall.
// Offsets include header_length, sampled with first_byte. Configuration
// writes take effect at once and must be made while no message is in flight.
module tlv_packet_field_extractor #(
  parameter int MAX_COMPONENTS = tpfe_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_ready,
  input  tpfe_pkg::byte_beat_t                byte_data,
  output logic                                result_valid,
  input  logic                                result_ready,
  output tpfe_pkg::result_beat_t              result_data,
  input  logic                                cfg_we,
  input  logic [tpfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpfe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam int NR    = tpfe_pkg::MAX_RESULTS;
  localparam int NR_W  = $clog2(NR + 1);

  typedef enum logic [3:0] {
    PH_MSG, PH_TOP, PH_SKIP, PH_NHDR, PH_CVAL, PH_MHDR, PH_MVAL, PH_DRAIN, PH_DONE
  } phase_t;

  // configuration
  logic [15:0] name_type, metadata_type, payload_type, chunk_type, end_chunk_type;

  // parser state
  phase_t      phase;
  logic [1:0]  header_count;
  logic [15:0] field_type, field_length, outer_remaining, inner_remaining;
  logic [15:0] byte_position, name_start, name_span_len;
  logic [CNT_W-1:0] component_count;
  logic [31:0] number_accumulator;
  logic        pay_seen;
  logic [15:0] pay_offset, pay_length;
  logic [2:0]  error_code;

  // next values
  phase_t      phase_next;
  logic [1:0]  header_count_next;
  logic [15:0] field_type_next, field_length_next, outer_remaining_next;
  logic [15:0] inner_remaining_next, byte_position_next, name_start_next;
  logic [15:0] name_span_len_next;
  logic [CNT_W-1:0] component_count_next;
  logic [31:0] number_accumulator_next;
  logic        pay_seen_next;
  logic [15:0] pay_offset_next, pay_length_next;
  logic [2:0]  error_code_next;

  // result bundle
  tpfe_pkg::result_beat_t bundle [NR];
  tpfe_pkg::result_beat_t bundle_next [NR];
  logic [NR_W-1:0] bundle_rem;
  logic [NR_W-1:0] res_cnt;
  logic            skip;
  logic            accept, drain;

  assign accept     = byte_valid && byte_ready;
  assign drain      = (bundle_rem != '0) && (!result_valid || result_ready);
  assign byte_ready = (bundle_rem == '0) || ((bundle_rem == NR_W'(1)) && drain);

  function automatic tpfe_pkg::result_beat_t mk(input logic [2:0] k,
                                                input logic [15:0] off,
                                                input logic [15:0] len,
                                                input logic [4:0] idx,
                                                input logic [31:0] num);
    tpfe_pkg::result_beat_t r;
    r = '0;
    r.kind   = k;
    r.offset = off;
    r.length = len;
    r.index  = idx;
    r.number = num;
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    phase_t      ph;
    logic [1:0]  hc;
    logic [15:0] ft, fl, outer, inner, pos, nstart, nsl, pl_off, pl_len;
    logic [15:0] ft_h, fl_h;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W+4:0] cnt_ext;
    logic [31:0] acc;
    logic        pl_seen, hdr_done, do_name, do_meta, do_fail;
    logic [2:0]  err, fail_code, st;
    logic [16:0] span_sum;

    b = byte_data.data_byte;
    if (byte_data.first_byte) begin
      ph = PH_MSG; hc = '0; ft = '0; fl = '0; outer = '0; inner = '0;
      pos = {8'd0, byte_data.header_length};
      nstart = '0; nsl = '0; cnt = '0; acc = '0;
      pl_seen = 1'b0; pl_off = '0; pl_len = '0; err = '0;
    end else begin
      ph = phase; hc = header_count; ft = field_type; fl = field_length;
      outer = outer_remaining; inner = inner_remaining; pos = byte_position;
      nstart = name_start; nsl = name_span_len; cnt = component_count;
      acc = number_accumulator; pl_seen = pay_seen; pl_off = pay_offset;
      pl_len = pay_length; err = error_code;
    end
    skip = !byte_data.first_byte && (phase == PH_DONE);

    phase_next = ph; header_count_next = hc; field_type_next = ft;
    field_length_next = fl; outer_remaining_next = outer;
    inner_remaining_next = inner; name_start_next = nstart;
    name_span_len_next = nsl; component_count_next = cnt;
    number_accumulator_next = acc; pay_seen_next = pl_seen;
    pay_offset_next = pl_off; pay_length_next = pl_len; error_code_next = err;
    byte_position_next = pos + 16'd1;

    // shared header collector
    ft_h     = (hc < 2'd2) ? {ft[7:0], b} : ft;
    fl_h     = (hc < 2'd2) ? fl : {fl[7:0], b};
    hdr_done = (hc == 2'd3);
    span_sum = {1'b0, fl_h} + 17'd4;

    do_name = 1'b0; do_meta = 1'b0; do_fail = 1'b0; fail_code = tpfe_pkg::ST_OK;
    res_cnt = '0;
    for (int i = 0; i < NR; i++) bundle_next[i] = '0;
    cnt_ext = (CNT_W+5)'(cnt);

    case (ph)
      PH_MSG: begin
        header_count_next = hdr_done ? 2'd0 : hc + 2'd1;
        field_type_next = ft_h; field_length_next = fl_h;
        if (hdr_done) phase_next = PH_TOP;
      end
      PH_TOP: begin
        header_count_next = hdr_done ? 2'd0 : hc + 2'd1;
        field_type_next = ft_h; field_length_next = fl_h;
        if (hdr_done) begin
          outer_remaining_next = fl_h;
          if (ft_h == name_type) begin
            name_start_next = pos - 16'd3;
            name_span_len_next = (span_sum > 17'hFFFF) ? 16'hFFFF : span_sum[15:0];
            do_name = 1'b1;
          end else if (ft_h == payload_type) begin
            pay_seen_next = 1'b1; pay_offset_next = pos + 16'd1; pay_length_next = fl_h;
            phase_next = (fl_h == '0) ? PH_TOP : PH_SKIP;
          end else if (ft_h == metadata_type) begin
            if (fl_h < 16'd4) begin
              do_fail = 1'b1; fail_code = tpfe_pkg::ST_TRUNC_META;
            end else begin
              phase_next = PH_MHDR;
            end
          end else begin
            phase_next = (fl_h == '0) ? PH_TOP : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        outer_remaining_next = outer - 16'd1;
        if (outer_remaining_next == '0) phase_next = PH_TOP;
      end
      PH_NHDR: begin
        outer_remaining_next = outer - 16'd1;
        header_count_next = hdr_done ? 2'd0 : hc + 2'd1;
        field_type_next = ft_h; field_length_next = fl_h;
        if (hdr_done) begin
          if (fl_h > outer_remaining_next) begin
            do_fail = 1'b1; fail_code = tpfe_pkg::ST_OVERRUN;
          end else begin
            if (cnt < CNT_W'(MAX_COMPONENTS)) begin
              bundle_next[res_cnt[1:0]] = mk(tpfe_pkg::KIND_COMPONENT, pos - 16'd3,
                                             fl_h + 16'd4, cnt_ext[4:0], '0);
              res_cnt = res_cnt + NR_W'(1);
              component_count_next = cnt + CNT_W'(1);
            end
            inner_remaining_next = fl_h;
            number_accumulator_next = '0;
            if (fl_h == '0) begin
              if (ft_h == chunk_type) begin
                bundle_next[res_cnt[1:0]] = mk(tpfe_pkg::KIND_CHUNK, pos + 16'd1,
                                               '0, '0, '0);
                res_cnt = res_cnt + NR_W'(1);
              end
              do_name = 1'b1;
            end else begin
              phase_next = PH_CVAL;
            end
          end
        end
      end
      PH_CVAL: begin
        outer_remaining_next = outer - 16'd1;
        inner_remaining_next = inner - 16'd1;
        number_accumulator_next = {acc[23:0], b};
        if (inner_remaining_next == '0) begin
          if (ft == chunk_type) begin
            bundle_next[res_cnt[1:0]] = mk(tpfe_pkg::KIND_CHUNK, pos + 16'd1 - fl, fl,
                                           '0, number_accumulator_next);
            res_cnt = res_cnt + NR_W'(1);
          end
          do_name = 1'b1;
        end
      end
      PH_MHDR: begin
        outer_remaining_next = outer - 16'd1;
        header_count_next = hdr_done ? 2'd0 : hc + 2'd1;
        field_type_next = ft_h; field_length_next = fl_h;
        if (hdr_done) begin
          if (fl_h > outer_remaining_next) begin
            do_fail = 1'b1; fail_code = tpfe_pkg::ST_OVERRUN;
          end else if (ft_h == end_chunk_type) begin
            inner_remaining_next = fl_h;
            number_accumulator_next = '0;
            if (fl_h == '0) begin
              bundle_next[res_cnt[1:0]] = mk(tpfe_pkg::KIND_END_CHUNK, pos + 16'd1,
                                             '0, '0, '0);
              res_cnt = res_cnt + NR_W'(1);
              do_meta = 1'b1;
            end else begin
              phase_next = PH_MVAL;
            end
          end else begin
            do_meta = 1'b1;
          end
        end
      end
      PH_MVAL: begin
        outer_remaining_next = outer - 16'd1;
        inner_remaining_next = inner - 16'd1;
        number_accumulator_next = {acc[23:0], b};
        if (inner_remaining_next == '0) begin
          bundle_next[res_cnt[1:0]] = mk(tpfe_pkg::KIND_END_CHUNK, pos + 16'd1 - fl, fl,
                                         '0, number_accumulator_next);
          res_cnt = res_cnt + NR_W'(1);
          do_meta = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // close out a component or the whole name
    if (do_name) begin
      if (outer_remaining_next == '0) begin
        bundle_next[res_cnt[1:0]] = mk(tpfe_pkg::KIND_NAME_SPAN, name_start_next,
                                       name_span_len_next, '0, '0);
        res_cnt = res_cnt + NR_W'(1);
        phase_next = PH_TOP;
      end else if (outer_remaining_next < 16'd4) begin
        do_fail = 1'b1; fail_code = tpfe_pkg::ST_TRUNC_COMP;
      end else begin
        phase_next = PH_NHDR;
      end
    end
    if (do_meta) phase_next = (outer_remaining_next == '0) ? PH_TOP : PH_SKIP;
    if (do_fail) begin
      error_code_next = fail_code;
      phase_next = PH_DRAIN;
    end

    if (byte_data.last_byte) begin
      if (error_code_next != tpfe_pkg::ST_OK) st = error_code_next;
      else if (phase_next == PH_MSG) st = tpfe_pkg::ST_SHORT_MSG_HDR;
      else if (phase_next == PH_TOP)
        st = (header_count_next != 2'd0) ? tpfe_pkg::ST_TRAILING : tpfe_pkg::ST_OK;
      else st = tpfe_pkg::ST_OVERRUN;
      cnt_ext = (CNT_W+5)'(component_count_next);
      bundle_next[res_cnt[1:0]] = mk(tpfe_pkg::KIND_DONE, '0, '0, cnt_ext[4:0], '0);
      bundle_next[res_cnt[1:0]].payload_offset = pay_offset_next;
      bundle_next[res_cnt[1:0]].payload_length = pay_length_next;
      bundle_next[res_cnt[1:0]].payload_seen   = pay_seen_next;
      bundle_next[res_cnt[1:0]].status         = st;
      res_cnt = res_cnt + NR_W'(1);
      phase_next = PH_DONE;
    end else begin
      st = tpfe_pkg::ST_OK;
    end

    if (res_cnt != '0) bundle_next[res_cnt[1:0] - 2'd1].last_result = 1'b1;
  end

  // state, configuration and control
  always_ff @(posedge clk) begin
    if (rst) begin
      name_type <= tpfe_pkg::RST_NAME_TYPE;
      metadata_type <= tpfe_pkg::RST_METADATA_TYPE;
      payload_type <= tpfe_pkg::RST_PAYLOAD_TYPE;
      chunk_type <= tpfe_pkg::RST_CHUNK_TYPE;
      end_chunk_type <= tpfe_pkg::RST_END_CHUNK_TYPE;
      phase <= PH_MSG;
      header_count <= '0; field_type <= '0; field_length <= '0;
      outer_remaining <= '0; inner_remaining <= '0; byte_position <= '0;
      name_start <= '0; name_span_len <= '0; component_count <= '0;
      number_accumulator <= '0; pay_seen <= 1'b0; pay_offset <= '0;
      pay_length <= '0; error_code <= '0;
      bundle_rem <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tpfe_pkg::REG_NAME_TYPE:      name_type <= cfg_wdata;
          tpfe_pkg::REG_METADATA_TYPE:  metadata_type <= cfg_wdata;
          tpfe_pkg::REG_PAYLOAD_TYPE:   payload_type <= cfg_wdata;
          tpfe_pkg::REG_CHUNK_TYPE:     chunk_type <= cfg_wdata;
          tpfe_pkg::REG_END_CHUNK_TYPE: end_chunk_type <= cfg_wdata;
          default: begin
          end
        endcase
      end
      // drop bytes after packet done until the next first byte
      if (accept && !skip) begin
        phase <= phase_next;
        header_count <= header_count_next;
        field_type <= field_type_next;
        field_length <= field_length_next;
        outer_remaining <= outer_remaining_next;
        inner_remaining <= inner_remaining_next;
        byte_position <= byte_position_next;
        name_start <= name_start_next;
        name_span_len <= name_span_len_next;
        component_count <= component_count_next;
        number_accumulator <= number_accumulator_next;
        pay_seen <= pay_seen_next;
        pay_offset <= pay_offset_next;
        pay_length <= pay_length_next;
        error_code <= error_code_next;
      end
      if (accept && !skip && (res_cnt != '0)) bundle_rem <= res_cnt;
      else if (drain) bundle_rem <= bundle_rem - NR_W'(1);
      if (drain) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  // bundle and output payload
  always_ff @(posedge clk) begin
    if (drain) result_data <= bundle[0];
    if (accept && !skip && (res_cnt != '0)) begin
      for (int i = 0; i < NR; i++) bundle[i] <= bundle_next[i];
    end else if (drain) begin
      // advance the bundle by one result
      for (int i = 0; i < NR - 1; i++) bundle[i] <= bundle[i+1];
    end
  end

endmodule

[src/tpfe_checker.sv]
// ---------------------------------------------------------------------------
// tpfe_checker
// Port-level checks for the TLV packet field extractor.
// ---------------------------------------------------------------------------
module tpfe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            byte_valid,
  input logic                            byte_ready,
  input tpfe_pkg::byte_beat_t            byte_data,
  input logic                            result_valid,
  input logic                            result_ready,
  input tpfe_pkg::result_beat_t          result_data
);

  // hold an offered byte beat until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
    else $error("offered byte beat changed before acceptance");

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("stalled result beat changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.kind == tpfe_pkg::KIND_DONE) |-> result_data.last_result)
    else $error("packet done is not the last result of its byte");

  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.kind != tpfe_pkg::KIND_DONE) |->
      (result_data.status == tpfe_pkg::ST_OK) && !result_data.payload_seen)
    else $error("status or payload fields set outside packet done");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && byte_ready)
    else $error("block not idle after reset");

endmodule

bind tlv_packet_field_extractor tpfe_checker u_tpfe_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .byte_data    (byte_data),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);
